// ----- design/rdf_pkg.sv -----
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared types, constants and tables of the decimal to fraction converter.
// ----------------------------------------------------------------------------
package rdf_pkg;

    localparam int MAX_CHARS_DEF = 19;
    localparam int WORD_W        = 64;
    localparam int VAL_W         = 63;
    localparam int COUNT_W       = 5;
    localparam int POW_N         = 19;

    localparam logic [WORD_W-1:0] LIM = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_PZERO,
        OP_RZERO,
        OP_FZERO,
        OP_GLOAD,
        OP_GSTEP,
        OP_NINES,
        OP_DIV,
        OP_MUL,
        OP_ADD,
        OP_CAPTURE
    } t_op;

    typedef enum logic [2:0] {
        SEL_PN,
        SEL_PD,
        SEL_RN,
        SEL_RD,
        SEL_DEN,
        SEL_NUM,
        SEL_GA,
        SEL_T1
    } t_sel;

    typedef struct packed {
        logic take;
        t_op  op;
        t_sel a;
        t_sel b;
        t_sel dst;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic ov;
        logic pn_zero;
        logic rn_zero;
        logic rep_empty;
        logic num_zero;
        logic gb_zero;
    } t_status;

    typedef logic [WORD_W-1:0] t_pow_tab [POW_N];

    function automatic t_pow_tab f_pow_tab();
        t_pow_tab           tab;
        logic [WORD_W-1:0]  v;
        v = 64'd1;
        for (int i = 0; i < POW_N; i++) begin
            tab[i] = v;
            v = v * 64'd10;
        end
        return tab;
    endfunction

    localparam t_pow_tab POW10 = f_pow_tab();

endpackage

// ----- design/rdf_in_if.sv -----
// ----------------------------------------------------------------------------
// rdf_in_if
// Character channel: one ASCII character per request and an end marker.
// ----------------------------------------------------------------------------
interface rdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- design/rdf_out_if.sv -----
// ----------------------------------------------------------------------------
// rdf_out_if
// Result channel: reduced fraction and overflow flag per request.
// ----------------------------------------------------------------------------
interface rdf_out_if;
    logic        valid;
    logic        ready;
    logic [62:0] numerator;
    logic [62:0] denominator;
    logic        overflow;

    modport source (output valid, output numerator, output denominator,
                    output overflow, input ready);
    modport sink   (input valid, input numerator, input denominator,
                    input overflow, output ready);
endinterface

// ----- design/repeating_decimal_to_fraction.sv -----
// ----------------------------------------------------------------------------
// repeating_decimal_to_fraction
// Converts a decimal string with an optional repeating part to a fraction.
// ----------------------------------------------------------------------------
// Characters are taken at one per cycle while the controller is in its parse state.
// After the last character the result is computed by divisions, gcd steps and
// multiplications in the shared bit-serial unit; the number of gcd steps sets
// the run time. The next string is taken once the result is held.
// Reset is synchronous and active low; it clears the parser and controller.
module repeating_decimal_to_fraction #(
    parameter int MAX_CHARS = rdf_pkg::MAX_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rdf_in_if.sink    i_in,
    rdf_out_if.source o_out
);
    import rdf_pkg::*;

    t_cmd    cmd;
    t_status st;
    logic    in_ready;
    logic    out_valid;

    rdf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last),
        .i_out_ready (o_out.ready),
        .i_status    (st),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    rdf_dp #(.MAX_CHARS(MAX_CHARS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_char_code   (i_in.char_code),
        .o_status      (st),
        .o_numerator   (o_out.numerator),
        .o_denominator (o_out.denominator),
        .o_overflow    (o_out.overflow)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    a_ov_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.overflow |-> o_out.numerator == '0 && o_out.denominator == 63'd1)
        else $error("Overflow result is not zero over one.");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.denominator != '0)
        else $error("Result denominator is zero.");

    a_no_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.busy |-> !(cmd.op == OP_DIV || cmd.op == OP_MUL || cmd.op == OP_GSTEP
                      || cmd.op == OP_GLOAD || cmd.op == OP_ADD))
        else $error("Command issued while the arithmetic unit is busy.");

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.last |=> !i_in.ready)
        else $error("Input still accepted after the final character.");
endmodule

// ----- design/rdf_arith.sv -----
// ----------------------------------------------------------------------------
// rdf_arith
// Shared bit-serial unit: restoring divider and shift-add multiplier.
// ----------------------------------------------------------------------------
module rdf_arith (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_mul,
    input  logic [63:0] i_x,
    input  logic [63:0] i_y,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem,
    output logic [63:0] o_prod,
    output logic        o_mul_ov
);
    import rdf_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [CNT_W-1:0]    r_cnt;
    logic                r_done;
    logic                r_mul;
    logic [WORD_W-1:0]   r_rem, r_quo, r_dvs, r_ma;
    logic [2*WORD_W-1:0] r_mb, r_acc;
    logic [WORD_W:0]     trial, diff;
    logic                ge;

    assign trial = {r_rem, r_quo[WORD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(WORD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mul <= i_mul;
            r_rem <= '0;
            r_quo <= i_x;
            r_dvs <= i_y;
            r_ma  <= i_x;
            r_mb  <= {{WORD_W{1'b0}}, i_y};
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            if (r_mul) begin
                if (r_ma[0]) begin
                    r_acc <= r_acc + r_mb;
                end
                r_ma <= r_ma >> 1;
                r_mb <= r_mb << 1;
            end else begin
                r_rem <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], ge};
            end
        end
    end

    assign o_busy   = r_cnt != '0;
    assign o_done   = r_done;
    assign o_quot   = r_quo;
    assign o_rem    = r_rem;
    assign o_prod   = r_acc[WORD_W-1:0];
    assign o_mul_ov = |r_acc[2*WORD_W-1:VAL_W];
endmodule

// ----- design/rdf_dp.sv -----
// ----------------------------------------------------------------------------
// rdf_dp
// Datapath: character parser, working registers and the arithmetic unit.
// ----------------------------------------------------------------------------
module rdf_dp #(
    parameter int MAX_CHARS = rdf_pkg::MAX_CHARS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rdf_pkg::t_cmd    i_cmd,
    input  logic [7:0]       i_char_code,
    output rdf_pkg::t_status o_status,
    output logic [62:0]      o_numerator,
    output logic [62:0]      o_denominator,
    output logic             o_overflow
);
    import rdf_pkg::*;

    localparam int SEEN_W = $clog2(MAX_CHARS + 1);

    typedef enum logic [1:0] {PH_INT, PH_FRAC, PH_REP, PH_DONE} t_phase;

    function automatic logic [WORD_W:0] f_append(logic [WORD_W-1:0] v, logic [3:0] d);
        logic [WORD_W+3:0] p;
        logic [WORD_W-1:0] m;
        logic [WORD_W:0]   s;
        logic              mo, ao;
        p  = ({4'b0, v} << 3) + ({4'b0, v} << 1);
        mo = p > {4'b0, LIM};
        m  = mo ? '0 : p[WORD_W-1:0];
        s  = {1'b0, m} + {{(WORD_W-3){1'b0}}, d};
        ao = s > {1'b0, LIM};
        return {mo | ao, ao ? {WORD_W{1'b0}} : s[WORD_W-1:0]};
    endfunction

    function automatic logic [WORD_W-1:0] f_pow(logic [COUNT_W-1:0] n);
        return (n < COUNT_W'(POW_N)) ? POW10[n] : '0;
    endfunction

    // Parser state.
    logic [WORD_W-1:0]  r_plain, n_plain, r_rep, n_rep;
    logic [COUNT_W-1:0] r_fc, n_fc, r_rc, n_rc;
    t_phase             r_phase, n_phase;
    logic               r_ovs, n_ovs;
    logic [SEEN_W-1:0]  r_seen, n_seen;

    // Working registers.
    logic [WORD_W-1:0]  r_pn, n_pn, r_pd, n_pd, r_rn, n_rn, r_rd, n_rd;
    logic [WORD_W-1:0]  r_den, n_den, r_num, n_num, r_ga, n_ga, r_gb, n_gb;
    logic [WORD_W-1:0]  r_t1, n_t1;
    logic               r_ov, n_ov, r_kz, n_kz, r_kbig, n_kbig;
    t_op                r_pend_op, n_pend_op;
    t_sel               r_pend_dst, n_pend_dst;
    logic [VAL_W-1:0]   r_onum, n_onum, r_oden, n_oden;
    logic               r_oov, n_oov;

    logic               digit;
    logic [3:0]         dval;
    logic [7:0]         doff;
    logic [WORD_W:0]    app_p, app_r, add_s;
    logic               add_ov;
    logic [WORD_W-1:0]  src_a, src_b, wval;
    logic               wen;
    t_sel               wdst;
    logic               ar_start, ar_busy, ar_done, ar_mul_ov;
    logic [WORD_W-1:0]  ar_x, ar_y, ar_quot, ar_rem, ar_prod;

    assign digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign doff  = i_char_code - CH_ZERO;
    assign dval  = digit ? doff[3:0] : 4'd0;
    assign app_p = f_append(r_plain, dval);
    assign app_r = f_append(r_rep, dval);

    always_comb begin
        n_plain = r_plain;
        n_rep   = r_rep;
        n_fc    = r_fc;
        n_rc    = r_rc;
        n_phase = r_phase;
        n_ovs   = r_ovs;
        n_seen  = r_seen;
        if (i_cmd.op == OP_INIT) begin
            n_plain = '0;
            n_rep   = '0;
            n_fc    = '0;
            n_rc    = '0;
            n_phase = PH_INT;
            n_ovs   = 1'b0;
            n_seen  = '0;
        end else if (i_cmd.take) begin
            if (r_seen >= SEEN_W'(MAX_CHARS)) begin
                n_ovs = 1'b1;
            end else begin
                n_seen = r_seen + 1'b1;
                case (r_phase)
                    PH_INT, PH_FRAC: begin
                        if (digit) begin
                            n_plain = app_p[WORD_W-1:0];
                            n_ovs   = r_ovs | app_p[WORD_W];
                            if (r_phase == PH_FRAC && r_fc != '1) begin
                                n_fc = r_fc + 1'b1;
                            end
                        end else if (i_char_code == CH_DOT && r_phase == PH_INT) begin
                            n_phase = PH_FRAC;
                        end else if (i_char_code == CH_OPEN) begin
                            n_phase = PH_REP;
                        end
                    end
                    PH_REP: begin
                        if (digit) begin
                            n_rep = app_r[WORD_W-1:0];
                            n_ovs = r_ovs | app_r[WORD_W];
                            if (r_rc != '1) begin
                                n_rc = r_rc + 1'b1;
                            end
                        end else if (i_char_code == CH_CLOSE) begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (i_cmd.a)
            SEL_PN:  src_a = r_pn;
            SEL_PD:  src_a = r_pd;
            SEL_RN:  src_a = r_rn;
            SEL_RD:  src_a = r_rd;
            SEL_DEN: src_a = r_den;
            SEL_NUM: src_a = r_num;
            SEL_GA:  src_a = r_ga;
            default: src_a = r_t1;
        endcase
        case (i_cmd.b)
            SEL_PN:  src_b = r_pn;
            SEL_PD:  src_b = r_pd;
            SEL_RN:  src_b = r_rn;
            SEL_RD:  src_b = r_rd;
            SEL_DEN: src_b = r_den;
            SEL_NUM: src_b = r_num;
            SEL_GA:  src_b = r_ga;
            default: src_b = r_t1;
        endcase
    end

    assign add_s  = {1'b0, src_a} + {1'b0, src_b};
    assign add_ov = (src_a > LIM) || (add_s > {1'b0, LIM});

    assign ar_start = (i_cmd.op == OP_DIV) || (i_cmd.op == OP_MUL) || (i_cmd.op == OP_GSTEP);
    assign ar_x     = (i_cmd.op == OP_GSTEP) ? r_ga : src_a;
    assign ar_y     = (i_cmd.op == OP_GSTEP) ? r_gb : src_b;

    rdf_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ar_start),
        .i_mul    (i_cmd.op == OP_MUL),
        .i_x      (ar_x),
        .i_y      (ar_y),
        .o_busy   (ar_busy),
        .o_done   (ar_done),
        .o_quot   (ar_quot),
        .o_rem    (ar_rem),
        .o_prod   (ar_prod),
        .o_mul_ov (ar_mul_ov)
    );

    always_comb begin
        n_pn       = r_pn;
        n_pd       = r_pd;
        n_rn       = r_rn;
        n_rd       = r_rd;
        n_den      = r_den;
        n_num      = r_num;
        n_ga       = r_ga;
        n_gb       = r_gb;
        n_t1       = r_t1;
        n_ov       = r_ov;
        n_kz       = r_kz;
        n_kbig     = r_kbig;
        n_pend_op  = r_pend_op;
        n_pend_dst = r_pend_dst;
        n_onum     = r_onum;
        n_oden     = r_oden;
        n_oov      = r_oov;
        wen        = 1'b0;
        wval       = '0;
        wdst       = i_cmd.dst;
        case (i_cmd.op)
            OP_INIT: begin
                n_pn   = r_plain;
                n_pd   = f_pow(r_fc);
                n_t1   = f_pow(r_fc);
                n_rn   = r_rep;
                n_rd   = f_pow(r_rc) - 64'd1;
                n_num  = '0;
                n_den  = 64'd1;
                n_ov   = r_ovs | (r_fc >= COUNT_W'(POW_N));
                n_kz   = r_rc == '0;
                n_kbig = r_rc >= COUNT_W'(POW_N);
            end
            OP_PZERO: begin
                n_pn = '0;
                n_pd = 64'd1;
            end
            OP_RZERO: begin
                n_rn = '0;
                n_rd = 64'd1;
            end
            OP_FZERO: begin
                n_num = '0;
                n_den = 64'd1;
            end
            OP_GLOAD: begin
                n_ga = src_a;
                n_gb = src_b;
            end
            OP_NINES: begin
                n_ov = r_ov | r_kbig;
            end
            OP_ADD: begin
                wen  = 1'b1;
                wval = add_ov ? '0 : add_s[WORD_W-1:0];
                n_ov = r_ov | add_ov;
            end
            OP_DIV, OP_MUL, OP_GSTEP: begin
                n_pend_op  = i_cmd.op;
                n_pend_dst = i_cmd.dst;
            end
            OP_CAPTURE: begin
                n_onum = r_num[VAL_W-1:0];
                n_oden = r_den[VAL_W-1:0];
                n_oov  = r_ov;
            end
            default: ;
        endcase
        if (ar_done) begin
            wdst = r_pend_dst;
            case (r_pend_op)
                OP_GSTEP: begin
                    n_ga = r_gb;
                    n_gb = ar_rem;
                end
                OP_DIV: begin
                    wen  = 1'b1;
                    wval = ar_quot;
                end
                OP_MUL: begin
                    wen  = 1'b1;
                    wval = ar_mul_ov ? '0 : ar_prod;
                    n_ov = r_ov | ar_mul_ov;
                end
                default: ;
            endcase
        end
        if (wen) begin
            case (wdst)
                SEL_PN:  n_pn  = wval;
                SEL_PD:  n_pd  = wval;
                SEL_RN:  n_rn  = wval;
                SEL_RD:  n_rd  = wval;
                SEL_DEN: n_den = wval;
                SEL_NUM: n_num = wval;
                SEL_GA:  n_ga  = wval;
                default: n_t1  = wval;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plain   <= '0;
            r_rep     <= '0;
            r_fc      <= '0;
            r_rc      <= '0;
            r_phase   <= PH_INT;
            r_ovs     <= 1'b0;
            r_seen    <= '0;
            r_pend_op <= OP_NONE;
        end else begin
            r_plain   <= n_plain;
            r_rep     <= n_rep;
            r_fc      <= n_fc;
            r_rc      <= n_rc;
            r_phase   <= n_phase;
            r_ovs     <= n_ovs;
            r_seen    <= n_seen;
            r_pend_op <= n_pend_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pn       <= n_pn;
        r_pd       <= n_pd;
        r_rn       <= n_rn;
        r_rd       <= n_rd;
        r_den      <= n_den;
        r_num      <= n_num;
        r_ga       <= n_ga;
        r_gb       <= n_gb;
        r_t1       <= n_t1;
        r_ov       <= n_ov;
        r_kz       <= n_kz;
        r_kbig     <= n_kbig;
        r_pend_dst <= n_pend_dst;
        r_onum     <= n_onum;
        r_oden     <= n_oden;
        r_oov      <= n_oov;
    end

    assign o_status.busy      = ar_busy | ar_done;
    assign o_status.ov        = r_ov;
    assign o_status.pn_zero   = r_pn == '0;
    assign o_status.rn_zero   = r_rn == '0;
    assign o_status.rep_empty = r_kz;
    assign o_status.num_zero  = r_num == '0;
    assign o_status.gb_zero   = r_gb == '0;

    assign o_numerator   = r_onum;
    assign o_denominator = r_oden;
    assign o_overflow    = r_oov;
endmodule

// ----- design/rdf_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdf_ctrl
// Controller: sequences parsing, the gcd reductions and the final sum.
// ----------------------------------------------------------------------------
module rdf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  logic             i_out_ready,
    input  rdf_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output rdf_pkg::t_cmd    o_cmd
);
    import rdf_pkg::*;

    typedef enum logic [4:0] {
        S_PARSE, S_INIT, S_PCHK, S_GLOOP, S_WAIT, S_PDIV1, S_PDIV2,
        S_RCHK, S_RMUL, S_RCHK2, S_RDIV1, S_RDIV2, S_LCHK, S_LDIV,
        S_LMUL, S_LCHK2, S_LM1, S_LD2, S_LM2, S_LADD, S_FCHK,
        S_FDIV1, S_FDIV2, S_EMIT
    } t_state;

    typedef enum logic [1:0] {RET_P, RET_R, RET_L, RET_F} t_ret;

    t_state r_state, r_after;
    t_ret   r_ret;
    logic   r_out_valid;
    logic   rep_go;

    assign rep_go = !i_status.ov && !i_status.rep_empty && !i_status.rn_zero;

    always_comb begin
        o_cmd.take = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.a    = SEL_PN;
        o_cmd.b    = SEL_PN;
        o_cmd.dst  = SEL_PN;
        case (r_state)
            S_PARSE: o_cmd.take = i_in_valid;
            S_INIT:  o_cmd.op = OP_INIT;
            S_PCHK: begin
                if (i_status.ov || i_status.pn_zero) begin
                    o_cmd.op = OP_PZERO;
                end else begin
                    o_cmd.op = OP_GLOAD;
                    o_cmd.a  = SEL_PN;
                    o_cmd.b  = SEL_PD;
                end
            end
            S_GLOOP: begin
                if (!i_status.gb_zero) begin
                    o_cmd.op = OP_GSTEP;
                end
            end
            S_PDIV1: begin
                o_cmd.op = OP_DIV; o_cmd.a = SEL_PN; o_cmd.b = SEL_GA; o_cmd.dst = SEL_PN;
            end
            S_PDIV2: begin
                o_cmd.op = OP_DIV; o_cmd.a = SEL_PD; o_cmd.b = SEL_GA; o_cmd.dst = SEL_PD;
            end
            S_RCHK:  o_cmd.op = rep_go ? OP_NINES : OP_RZERO;
            S_RMUL: begin
                o_cmd.op = OP_MUL; o_cmd.a = SEL_RD; o_cmd.b = SEL_T1; o_cmd.dst = SEL_RD;
            end
            S_RCHK2: begin
                if (i_status.ov) begin
                    o_cmd.op = OP_RZERO;
                end else begin
                    o_cmd.op = OP_GLOAD;
                    o_cmd.a  = SEL_RN;
                    o_cmd.b  = SEL_RD;
                end
            end
            S_RDIV1: begin
                o_cmd.op = OP_DIV; o_cmd.a = SEL_RN; o_cmd.b = SEL_GA; o_cmd.dst = SEL_RN;
            end
            S_RDIV2: begin
                o_cmd.op = OP_DIV; o_cmd.a = SEL_RD; o_cmd.b = SEL_GA; o_cmd.dst = SEL_RD;
            end
            S_LCHK: begin
                if (!i_status.ov) begin
                    o_cmd.op = OP_GLOAD;
                    o_cmd.a  = SEL_RD;
                    o_cmd.b  = SEL_PD;
                end
            end
            S_LDIV: begin
                o_cmd.op = OP_DIV; o_cmd.a = SEL_RD; o_cmd.b = SEL_GA; o_cmd.dst = SEL_T1;
            end
            S_LMUL: begin
                o_cmd.op = OP_MUL; o_cmd.a = SEL_T1; o_cmd.b = SEL_PD; o_cmd.dst = SEL_DEN;
            end
            S_LCHK2: begin
                if (!i_status.ov) begin
                    o_cmd.op = OP_DIV; o_cmd.a = SEL_DEN; o_cmd.b = SEL_RD;
                    o_cmd.dst = SEL_T1;
                end
            end
            S_LM1: begin
                o_cmd.op = OP_MUL; o_cmd.a = SEL_RN; o_cmd.b = SEL_T1; o_cmd.dst = SEL_NUM;
            end
            S_LD2: begin
                o_cmd.op = OP_DIV; o_cmd.a = SEL_DEN; o_cmd.b = SEL_PD; o_cmd.dst = SEL_T1;
            end
            S_LM2: begin
                o_cmd.op = OP_MUL; o_cmd.a = SEL_PN; o_cmd.b = SEL_T1; o_cmd.dst = SEL_T1;
            end
            S_LADD: begin
                o_cmd.op = OP_ADD; o_cmd.a = SEL_NUM; o_cmd.b = SEL_T1; o_cmd.dst = SEL_NUM;
            end
            S_FCHK: begin
                if (i_status.ov || i_status.num_zero) begin
                    o_cmd.op = OP_FZERO;
                end else begin
                    o_cmd.op = OP_GLOAD;
                    o_cmd.a  = SEL_DEN;
                    o_cmd.b  = SEL_NUM;
                end
            end
            S_FDIV1: begin
                o_cmd.op = OP_DIV; o_cmd.a = SEL_NUM; o_cmd.b = SEL_GA; o_cmd.dst = SEL_NUM;
            end
            S_FDIV2: begin
                o_cmd.op = OP_DIV; o_cmd.a = SEL_DEN; o_cmd.b = SEL_GA; o_cmd.dst = SEL_DEN;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = OP_CAPTURE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PARSE;
            r_after     <= S_PARSE;
            r_ret       <= RET_P;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_PARSE: begin
                    if (i_in_valid && i_in_last) begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: r_state <= S_PCHK;
                S_PCHK: begin
                    if (i_status.ov || i_status.pn_zero) begin
                        r_state <= S_RCHK;
                    end else begin
                        r_ret   <= RET_P;
                        r_state <= S_GLOOP;
                    end
                end
                S_GLOOP: begin
                    if (!i_status.gb_zero) begin
                        r_after <= S_GLOOP;
                        r_state <= S_WAIT;
                    end else begin
                        case (r_ret)
                            RET_P:   r_state <= S_PDIV1;
                            RET_R:   r_state <= S_RDIV1;
                            RET_L:   r_state <= S_LDIV;
                            default: r_state <= S_FDIV1;
                        endcase
                    end
                end
                S_WAIT: begin
                    if (!i_status.busy) begin
                        r_state <= r_after;
                    end
                end
                S_PDIV1: begin r_after <= S_PDIV2; r_state <= S_WAIT; end
                S_PDIV2: begin r_after <= S_RCHK;  r_state <= S_WAIT; end
                S_RCHK:  r_state <= rep_go ? S_RMUL : S_LCHK;
                S_RMUL:  begin r_after <= S_RCHK2; r_state <= S_WAIT; end
                S_RCHK2: begin
                    if (i_status.ov) begin
                        r_state <= S_LCHK;
                    end else begin
                        r_ret   <= RET_R;
                        r_state <= S_GLOOP;
                    end
                end
                S_RDIV1: begin r_after <= S_RDIV2; r_state <= S_WAIT; end
                S_RDIV2: begin r_after <= S_LCHK;  r_state <= S_WAIT; end
                S_LCHK: begin
                    if (i_status.ov) begin
                        r_state <= S_FCHK;
                    end else begin
                        r_ret   <= RET_L;
                        r_state <= S_GLOOP;
                    end
                end
                S_LDIV:  begin r_after <= S_LMUL;  r_state <= S_WAIT; end
                S_LMUL:  begin r_after <= S_LCHK2; r_state <= S_WAIT; end
                S_LCHK2: begin
                    if (i_status.ov) begin
                        r_state <= S_FCHK;
                    end else begin
                        r_after <= S_LM1;
                        r_state <= S_WAIT;
                    end
                end
                S_LM1:   begin r_after <= S_LD2;  r_state <= S_WAIT; end
                S_LD2:   begin r_after <= S_LM2;  r_state <= S_WAIT; end
                S_LM2:   begin r_after <= S_LADD; r_state <= S_WAIT; end
                S_LADD:  r_state <= S_FCHK;
                S_FCHK: begin
                    if (i_status.ov || i_status.num_zero) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_ret   <= RET_F;
                        r_state <= S_GLOOP;
                    end
                end
                S_FDIV1: begin r_after <= S_FDIV2; r_state <= S_WAIT; end
                S_FDIV2: begin r_after <= S_EMIT;  r_state <= S_WAIT; end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_PARSE;
                    end
                end
                default: r_state <= S_PARSE;
            endcase
        end
    end

    assign o_in_ready  = r_state == S_PARSE;
    assign o_out_valid = r_out_valid;
endmodule
